// ===== hdl/mcir_pkg.sv =====
// ----------------------------------------------------------------------------
// mcir_pkg
// Shared types and constants for the coil / discrete input responder.
// ----------------------------------------------------------------------------
package mcir_pkg;

  localparam int DEF_NUM_COILS  = 2;
  localparam int DEF_NUM_INPUTS = 1;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;
  localparam int FRAME_MAX  = 6;
  localparam int IDX_W      = 3;

  localparam logic [7:0]  SID_RESET     = 8'd1;
  localparam logic [15:0] COIL_ON_WORD  = 16'hFF00;
  localparam logic [7:0]  EXC_FLAG      = 8'h80;
  localparam logic [7:0]  EXC_ILL_FUNC  = 8'd1;
  localparam logic [7:0]  EXC_ILL_ADDR  = 8'd2;

  localparam logic [7:0]  FN_READ_INPUTS = 8'd2;
  localparam logic [7:0]  FN_WRITE_COIL  = 8'd5;
  localparam logic [7:0]  FN_WRITE_COILS = 8'd15;

  localparam logic        OP_REQUEST = 1'b0;
  localparam logic        OP_BUTTON  = 1'b1;

  localparam logic [1:0]  ST_OK          = 2'd0;
  localparam logic [1:0]  ST_BAD_SIZE    = 2'd1;
  localparam logic [1:0]  ST_BAD_CRC     = 2'd2;
  localparam logic [1:0]  ST_UNSUPPORTED = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SEND
  } state_t;

  typedef enum logic [2:0] {
    FR_NONE,
    FR_EXC_FUNC,
    FR_EXC_ADDR,
    FR_READ,
    FR_ECHO_VAL,
    FR_ECHO_QTY
  } frame_kind_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic respond;
    logic last;
  } dp_sts_t;

endpackage

// ===== hdl/mcir_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcir_ctrl
// Sequencer: takes a request, has the datapath decode it, then, if there
// is a response, walks the response bytes out one per accepted output beat.
// ----------------------------------------------------------------------------
module mcir_ctrl
  import mcir_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        state_next = sts.respond ? S_SEND : S_IDLE;
      end
      S_SEND: begin
        if (out_ready && sts.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_DECODE: begin
        cmd.commit = 1'b1;
      end
      S_SEND: begin
        out_valid = 1'b1;
        cmd.step  = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/mcir_dp.sv =====
// ----------------------------------------------------------------------------
// mcir_dp
// Datapath: request capture, range checks, latch and coil state, and the
// response frame buffer with its byte pointer.
// ----------------------------------------------------------------------------
module mcir_dp
  import mcir_pkg::*;
#(
  parameter int NUM_COILS  = DEF_NUM_COILS,
  parameter int NUM_INPUTS = DEF_NUM_INPUTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_user,
  input  logic [IN_DATA_W-1:0] in_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output logic [7:0]           resp_byte,
  output logic                 resp_last,
  output logic [7:0]           coil_outputs
);

  // captured request
  logic        req_op;
  logic [1:0]  req_status;
  logic [7:0]  req_slave;
  logic [7:0]  req_fn;
  logic [15:0] req_addr;
  logic [15:0] req_qty;
  logic [15:0] req_val;
  logic [7:0]  req_bcount;
  logic [7:0]  req_bits;
  logic        req_level;

  logic [7:0]           own_id;
  logic                 press_latch;
  logic [NUM_COILS-1:0] coil_state;

  logic [7:0]       frame [FRAME_MAX];
  logic [IDX_W-1:0] frame_len;
  logic [IDX_W-1:0] idx;

  frame_kind_t          kind;
  logic [16:0]          addr_end;
  logic [16:0]          bc_expect;
  logic                 sid_match;
  logic                 input0_hit;
  logic                 input0_val;
  logic [NUM_COILS-1:0] coil_state_next;
  logic [7:0]           hdr_fn;
  logic [7:0]           b2, b3, b4, b5;
  logic [IDX_W-1:0]     len_next;

  always_comb begin
    addr_end   = {1'b0, req_addr} + {1'b0, req_qty};
    bc_expect  = ({1'b0, req_qty} + 17'd7) >> 3;
    sid_match  = (req_slave == own_id);
    input0_hit = (req_addr == 16'd0) && (req_qty != 16'd0);
    input0_val = press_latch | ~req_level;
  end

  always_comb begin
    kind = FR_NONE;
    if (req_op == OP_REQUEST) begin
      case (req_status)
        ST_UNSUPPORTED: begin
          if (sid_match) kind = FR_EXC_FUNC;
        end
        ST_OK: begin
          if (sid_match) begin
            case (req_fn)
              FN_READ_INPUTS: begin
                kind = (addr_end > 17'(NUM_INPUTS)) ? FR_EXC_ADDR : FR_READ;
              end
              FN_WRITE_COIL: begin
                kind = (req_addr >= 16'(NUM_COILS)) ? FR_EXC_ADDR : FR_ECHO_VAL;
              end
              FN_WRITE_COILS: begin
                if (addr_end > 17'(NUM_COILS) || bc_expect != {9'd0, req_bcount})
                  kind = FR_EXC_ADDR;
                else
                  kind = FR_ECHO_QTY;
              end
              default: kind = FR_NONE;
            endcase
          end
        end
        default: kind = FR_NONE;
      endcase
    end
  end

  // coil updates; the range checks above keep addr + i inside the coil set
  always_comb begin
    coil_state_next = coil_state;
    for (int j = 0; j < NUM_COILS; j++) begin
      if (kind == FR_ECHO_VAL && req_addr == 16'(j))
        coil_state_next[j] = (req_val == COIL_ON_WORD);
      if (kind == FR_ECHO_QTY && 17'(j) >= {1'b0, req_addr} && 17'(j) < addr_end)
        coil_state_next[j] = req_bits[3'(j - int'(req_addr[3:0]))];
    end
  end

  always_comb begin
    hdr_fn   = req_fn;
    b2       = 8'd0;
    b3       = 8'd0;
    b4       = 8'd0;
    b5       = 8'd0;
    len_next = 3'd3;
    case (kind)
      FR_EXC_FUNC: begin
        hdr_fn = req_fn | EXC_FLAG;
        b2     = EXC_ILL_FUNC;
      end
      FR_EXC_ADDR: begin
        hdr_fn = req_fn | EXC_FLAG;
        b2     = EXC_ILL_ADDR;
      end
      FR_READ: begin
        b2       = (req_qty != 16'd0) ? 8'd1 : 8'd0;
        b3       = {7'd0, input0_hit & input0_val};
        len_next = (req_qty != 16'd0) ? 3'd4 : 3'd3;
      end
      FR_ECHO_VAL: begin
        b2       = req_addr[15:8];
        b3       = req_addr[7:0];
        b4       = req_val[15:8];
        b5       = req_val[7:0];
        len_next = 3'd6;
      end
      FR_ECHO_QTY: begin
        b2       = req_addr[15:8];
        b3       = req_addr[7:0];
        b4       = req_qty[15:8];
        b5       = req_qty[7:0];
        len_next = 3'd6;
      end
      default: len_next = 3'd3;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op     <= in_user;
      req_status <= in_data[1:0];
      req_slave  <= in_data[9:2];
      req_fn     <= in_data[17:10];
      req_addr   <= in_data[33:18];
      req_qty    <= in_data[49:34];
      req_val    <= in_data[65:50];
      req_bcount <= in_data[73:66];
      req_bits   <= in_data[81:74];
      req_level  <= in_data[82];
    end
    if (cmd.commit) begin
      frame[0]  <= own_id;
      frame[1]  <= hdr_fn;
      frame[2]  <= b2;
      frame[3]  <= b3;
      frame[4]  <= b4;
      frame[5]  <= b5;
      frame_len <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id      <= SID_RESET;
      press_latch <= 1'b0;
      coil_state  <= '0;
      idx         <= '0;
    end else begin
      if (cfg_we) own_id <= cfg_wdata;
      if (cmd.commit) begin
        coil_state <= coil_state_next;
        idx        <= '0;
        if (req_op == OP_BUTTON)
          press_latch <= 1'b1;
        else if (kind == FR_READ && input0_hit)
          press_latch <= 1'b0;
      end else if (cmd.step) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_comb begin
    sts.respond  = (kind != FR_NONE);
    sts.last     = (idx == frame_len - 3'd1);
    resp_byte    = frame[idx];
    resp_last    = sts.last;
    coil_outputs = '0;
    coil_outputs[NUM_COILS-1:0] = coil_state;
  end

endmodule

// ===== hdl/modbus_coil_input_responder.sv =====
// ----------------------------------------------------------------------------
// modbus_coil_input_responder
// Responder for decoded Modbus requests on coils and discrete inputs.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken while idle, decoded in the next,
// then the response bytes go out one per accepted output beat. A
// response holds 3, 4 or 6 bytes; a button event or a silently dropped
// request gives none. The frame byte counter in the datapath steps on each
// accepted beat. coil_outputs in each response beat shows the coil bits
// after the request took effect.
module modbus_coil_input_responder
  import mcir_pkg::*;
#(
  parameter int NUM_COILS  = DEF_NUM_COILS,
  parameter int NUM_INPUTS = DEF_NUM_INPUTS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] read_status, [9:2] request_slave, [17:10] function_code,
  // [33:18] start_address, [49:34] quantity, [65:50] coil_value,
  // [73:66] byte_count, [81:74] coil_bits, [82] button_level, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] resp_byte, [15:8] coil_outputs
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic [7:0] resp_byte;
  logic [7:0] coil_outputs;

  mcir_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mcir_dp #(
    .NUM_COILS  (NUM_COILS),
    .NUM_INPUTS (NUM_INPUTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_user      (s_axis_tuser),
    .in_data      (s_axis_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .resp_byte    (resp_byte),
    .resp_last    (m_axis_tlast),
    .coil_outputs (coil_outputs)
  );

  assign m_axis_tdata = {coil_outputs, resp_byte};

endmodule

// ===== hdl/mcir_checker.sv =====
// ----------------------------------------------------------------------------
// mcir_checker
// Port-level checks on the responder, bound to the top level.
// ----------------------------------------------------------------------------
module mcir_checker
  import mcir_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // a response beat held by the sink keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("response beat changed while stalled");

  // one request in flight: never taking a request while a response is out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken during a response");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("no decode cycle after a request");

  a_end_of_frame: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("response continued past its last byte");

endmodule

bind modbus_coil_input_responder mcir_checker u_mcir_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
